// ----- rtl/core/deq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue with positional edit.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEFAULT_DEPTH      = 64;
  localparam int DEFAULT_DATA_WIDTH = 32;

  localparam int KIND_W   = 4;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_BACK  = 4'd0,
    KIND_PUSH_FRONT = 4'd1,
    KIND_POP_BACK   = 4'd2,
    KIND_POP_FRONT  = 4'd3,
    KIND_PEEK_FRONT = 4'd4,
    KIND_PEEK_BACK  = 4'd5,
    KIND_READ       = 4'd6,
    KIND_WRITE      = 4'd7,
    KIND_INSERT     = 4'd8,
    KIND_ERASE      = 4'd9,
    KIND_CLEAR      = 4'd10
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_OPEN,   // cell at index loads word, cells above take from below
    CM_CLOSE,  // cells at or above index take from above
    CM_WRITE   // cell at index loads word
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
  } cell_ctl_t;

endpackage

// ----- rtl/core/deq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels for requests and results of the queue.
// ----------------------------------------------------------------------------
interface deq_req_if;
  import deq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink (input valid, kind, position, value, output ready);
endinterface

interface deq_rsp_if;
  import deq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] data_out;
  logic [STATUS_W-1:0]       status;
  logic [FILL_W-1:0]         fill;

  modport source (output valid, data_out, status, fill, input ready);
  modport sink (input valid, data_out, status, fill, output ready);
endinterface

// ----- rtl/core/deq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row; loads, holds or shifts from a neighbor.
// ----------------------------------------------------------------------------
module deq_cell
  import deq_pkg::*;
#(
  parameter int DW  = DEFAULT_DATA_WIDTH,
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [IW-1:0] at,
  input  logic [DW-1:0] word,
  input  logic [DW-1:0] lo_q,
  input  logic [DW-1:0] hi_q,
  output logic [DW-1:0] q
);

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [DW-1:0] q_r;
  logic [DW-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    unique case (ctl.mode)
      CM_OPEN: begin
        if (MyIdx == at) q_nxt = word;
        else if (MyIdx > at) q_nxt = lo_q;
      end
      CM_CLOSE: begin
        if (MyIdx >= at) q_nxt = hi_q;
      end
      CM_WRITE: begin
        if (MyIdx == at) q_nxt = word;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- rtl/core/double_ended_queue_with_positional_edit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_with_positional_edit
// Bounded deque of signed words with push, pop and peek at both ends, clear,
// and positional read, write, insert and erase.
// ----------------------------------------------------------------------------
// One request per clock: the store is a row of DEPTH cells that shift in
// parallel, so push, pop, insert and erase complete in the cycle the request
// beat is taken, and the result appears in the output register in the next
// cycle. A new request is taken whenever the output register is empty or its
// beat is being taken in the same cycle. The read path for pop, peek and read
// is one DEPTH-to-one select across the cells. No clearing pass after reset;
// entries past the count are never read.
// ----------------------------------------------------------------------------
module double_ended_queue_with_positional_edit
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEFAULT_DEPTH,
  parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
  input logic       clk,
  input logic       rst_n,
  deq_req_if.sink   in_req,
  deq_rsp_if.source out_rsp
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic signed [VALUE_W-1:0] out_data_r;
  logic signed [VALUE_W-1:0] out_data_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [STATUS_W-1:0] out_status_nxt;
  logic [FILL_W-1:0]   out_fill_r;
  logic [FILL_W-1:0]   out_fill_nxt;

  logic            fire;
  kind_t           kind;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CW-1:0]   cnt_m1;
  logic            full;
  logic            empty;
  logic signed [63:0]   value_ext;
  logic [DATA_WIDTH-1:0] word;
  logic [IW-1:0]   rd_idx;
  logic            rd_en;
  logic [DATA_WIDTH-1:0] rd_word;
  logic signed [63:0]   rd_ext;
  status_t         status;
  cell_ctl_t       ctl;
  logic [IW-1:0]   at;

  logic [DATA_WIDTH-1:0] cell_q [DEPTH];

  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign fire         = in_req.valid && in_req.ready;

  assign kind      = kind_t'(in_req.kind);
  assign pos_ext   = CMPW'(in_req.position);
  assign cnt_ext   = CMPW'(count_r);
  assign cnt_m1    = count_r - 1'b1;
  assign full      = (count_r == FullCount);
  assign empty     = (count_r == '0);
  assign value_ext = 64'(in_req.value);
  assign word      = value_ext[DATA_WIDTH-1:0];

  assign rd_word = cell_q[rd_idx];
  assign rd_ext  = 64'(signed'(rd_word));

  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    ctl.mode  = CM_HOLD;
    at        = '0;
    rd_idx    = '0;
    rd_en     = 1'b0;
    unique case (kind)
      KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctl.mode  = (kind == KIND_PUSH_BACK) ? CM_WRITE : CM_OPEN;
          at        = (kind == KIND_PUSH_BACK) ? count_r[IW-1:0] : '0;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_POP_BACK, KIND_POP_FRONT, KIND_PEEK_FRONT, KIND_PEEK_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_en  = 1'b1;
          rd_idx = (kind == KIND_POP_BACK || kind == KIND_PEEK_BACK) ?
                   cnt_m1[IW-1:0] : '0;
          if (kind == KIND_POP_BACK) begin
            count_nxt = cnt_m1;
          end else if (kind == KIND_POP_FRONT) begin
            ctl.mode  = CM_CLOSE;
            count_nxt = cnt_m1;
          end
        end
      end
      KIND_READ, KIND_WRITE, KIND_ERASE: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_RANGE;
        end else begin
          at = pos_ext[IW-1:0];
          if (kind == KIND_READ) begin
            rd_en  = 1'b1;
            rd_idx = pos_ext[IW-1:0];
          end else if (kind == KIND_WRITE) begin
            ctl.mode = CM_WRITE;
          end else begin
            ctl.mode  = CM_CLOSE;
            count_nxt = cnt_m1;
          end
        end
      end
      KIND_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end else begin
          ctl.mode  = CM_OPEN;
          at        = pos_ext[IW-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_CLEAR: count_nxt = '0;
      default: status = ST_OK;
    endcase
    if (!fire) begin
      ctl.mode  = CM_HOLD;
      count_nxt = count_r;
    end
  end

  // output register; a new beat replaces one being taken
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    if (fire) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = rd_en ? rd_ext[VALUE_W-1:0] : '0;
      out_status_nxt = status;
      out_fill_nxt   = FILL_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.data_out = out_data_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.fill     = out_fill_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lo_q;
    logic [DATA_WIDTH-1:0] hi_q;
    if (i == 0) begin : g_first
      assign lo_q = '0;
    end else begin : g_lo
      assign lo_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign hi_q = cell_q[i];
    end else begin : g_hi
      assign hi_q = cell_q[i+1];
    end
    deq_cell #(
      .DW  (DATA_WIDTH),
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .at   (at),
      .word (word),
      .lo_q (lo_q),
      .hi_q (hi_q),
      .q    (cell_q[i])
    );
  end

endmodule
